### rtl/mtg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package mtg_pkg;

  localparam int MAX_VERTICES_DEF = 1024;
  localparam int IDX_W = 10;
  localparam int DVD_W = 52;
  localparam int DVS_W = 34;

  localparam logic [1:0] CMD_LOAD = 2'd0;
  localparam logic [1:0] CMD_TRI  = 2'd1;
  localparam logic [1:0] CMD_FIN  = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_DEGEN = 2'd1;
  localparam logic [1:0] ST_ZERO  = 2'd2;
  localparam logic [1:0] ST_SAT   = 2'd3;

  typedef struct packed {
    logic [1:0]        command;
    logic [IDX_W-1:0]  index_a;
    logic [IDX_W-1:0]  index_b;
    logic [IDX_W-1:0]  index_c;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_z;
    logic signed [15:0] tex_u;
    logic signed [15:0] tex_v;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
  } mtg_in_t;

  typedef struct packed {
    logic [IDX_W-1:0]   vertex_index;
    logic signed [15:0] tangent_x;
    logic signed [15:0] tangent_y;
    logic signed [15:0] tangent_z;
    logic [1:0]         status;
  } mtg_out_t;

  typedef struct packed {
    mtg_in_t          item;
    logic [IDX_W-1:0] slot_a;
    logic [IDX_W-1:0] slot_b;
    logic [IDX_W-1:0] slot_c;
  } mtg_job_t;

  typedef struct packed {
    logic     valid;
    mtg_job_t job;
  } mtg_head_t;

endpackage
`default_nettype wire

### rtl/mesh_tangent_generator_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel  | Ports                         | Handshake
// ---------+-------------------------------+-------------------------------
// input    | start, busy, in_item          | taken when start && !busy
// result   | out_valid, out_item           | one-cycle strobe, no back-pressure
// config   | cfg_we, cfg_wdata             | written when cfg_we
//
// Load and unused commands are answered from the idle state in the back end. Both
// triangles and finalizes run the shared 52-step restoring divider three times per
// item; a finalize also runs the 32-step square root. Index wrapping in the front
// end keeps an item in the holding stage while an index is not below the table
// size. Synchronous active-low reset; tables need no clearing pass.
// busy is high while the front holding stage cannot take an item.
module mesh_tangent_generator_core #(
  parameter int MAX_VERTICES = mtg_pkg::MAX_VERTICES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  mtg_pkg::mtg_in_t  in_item,
  output logic              out_valid,
  output mtg_pkg::mtg_out_t out_item,
  input  logic              cfg_we,
  input  logic [15:0]       cfg_wdata
);
  import mtg_pkg::*;

  logic [15:0] limit_r;
  mtg_head_t   head;
  logic        pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= '0;
    end else if (cfg_we) begin
      limit_r <= cfg_wdata;
    end
  end

  mtg_front #(.MAX_VERTICES(MAX_VERTICES)) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .in_item (in_item),
    .head    (head),
    .pop     (pop)
  );

  mtg_engine #(.MAX_VERTICES(MAX_VERTICES)) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .limit     (limit_r),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule
`default_nettype wire

### rtl/mtg_div.sv
`timescale 1ns / 1ps
`default_nettype none
module mtg_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [mtg_pkg::DVD_W-1:0] dividend,
  input  logic [mtg_pkg::DVS_W-1:0] divisor,
  output logic                      busy,
  output logic                      done,
  output logic [mtg_pkg::DVD_W-1:0] quotient
);
  import mtg_pkg::*;

  localparam int CNT_W = $clog2(DVD_W);

  logic             busy_r, done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DVS_W-1:0] rem_r, dvs_r, rem_nxt;
  logic [DVD_W-1:0] dq_r, dq_nxt;
  logic [DVS_W:0]   trial;

  always_comb begin
    trial = {rem_r, dq_r[DVD_W-1]};
    if (trial >= {1'b0, dvs_r}) begin
      rem_nxt = DVS_W'(trial - {1'b0, dvs_r});
      dq_nxt  = {dq_r[DVD_W-2:0], 1'b1};
    end else begin
      rem_nxt = trial[DVS_W-1:0];
      dq_nxt  = {dq_r[DVD_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        rem_r  <= '0;
        dq_r   <= dividend;
        dvs_r  <= divisor;
      end else if (busy_r) begin
        rem_r <= rem_nxt;
        dq_r  <= dq_nxt;
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DVD_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign busy     = busy_r;
  assign done     = done_r;
  assign quotient = dq_r;

endmodule
`default_nettype wire

### rtl/mtg_front.sv
`timescale 1ns / 1ps
`default_nettype none
module mtg_front #(
  parameter int MAX_VERTICES = mtg_pkg::MAX_VERTICES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  mtg_pkg::mtg_in_t   in_item,
  output mtg_pkg::mtg_head_t head,
  input  logic               pop
);
  import mtg_pkg::*;

  localparam int QDEPTH = 2;
  localparam int PW     = $clog2(QDEPTH);
  localparam logic [16:0] MAXV = 17'(MAX_VERTICES);

  logic             hold_valid_r;
  mtg_job_t         hold_r;
  mtg_job_t         q_r [QDEPTH];
  logic [PW-1:0]    wp_r, rp_r;
  logic [PW:0]      cnt_r;
  logic             ge_a, ge_b, ge_c, wrap_pending, push;

  // indices wrap by repeated subtraction, one step a cycle
  assign ge_a = {7'b0, hold_r.slot_a} >= MAXV;
  assign ge_b = {7'b0, hold_r.slot_b} >= MAXV;
  assign ge_c = {7'b0, hold_r.slot_c} >= MAXV;
  assign wrap_pending = ge_a || ge_b || ge_c;
  assign push = hold_valid_r && !wrap_pending && (cnt_r != (PW+1)'(QDEPTH));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
    end else begin
      if (start && !hold_valid_r) begin
        hold_valid_r  <= 1'b1;
        hold_r.item   <= in_item;
        hold_r.slot_a <= in_item.index_a;
        hold_r.slot_b <= in_item.index_b;
        hold_r.slot_c <= in_item.index_c;
      end else if (hold_valid_r && wrap_pending) begin
        if (ge_a) hold_r.slot_a <= IDX_W'({7'b0, hold_r.slot_a} - MAXV);
        if (ge_b) hold_r.slot_b <= IDX_W'({7'b0, hold_r.slot_b} - MAXV);
        if (ge_c) hold_r.slot_c <= IDX_W'({7'b0, hold_r.slot_c} - MAXV);
      end else if (push) begin
        hold_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        q_r[wp_r] <= hold_r;
        wp_r      <= wp_r + 1'b1;
      end
      if (pop) rp_r <= rp_r + 1'b1;
      if (push && !pop) cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

  assign busy       = hold_valid_r;
  assign head.valid = cnt_r != '0;
  assign head.job   = q_r[rp_r];

endmodule
`default_nettype wire

### rtl/mtg_engine.sv
`timescale 1ns / 1ps
`default_nettype none
module mtg_engine #(
  parameter int MAX_VERTICES = mtg_pkg::MAX_VERTICES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [15:0]        limit,
  input  mtg_pkg::mtg_head_t head,
  output logic               pop,
  output logic               out_valid,
  output mtg_pkg::mtg_out_t  out_item
);
  import mtg_pkg::*;

  localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;

  typedef enum logic [4:0] {
    S_IDLE, S_TRD, S_TCAP, S_TM0, S_TM1, S_TM2, S_TCHK, S_TN0, S_TN1, S_TN2,
    S_TDIV, S_TSRD, S_TSADD, S_FRD, S_FCAP, S_FD0, S_FD1, S_FD2, S_FD3,
    S_FP0, S_FP1, S_FSH, S_FQ0, S_FQ1, S_FQ2, S_FQ3, S_FSQ, S_FLEN,
    S_FDV, S_FDW, S_FWB
  } state_t;

  logic [47:0] pos_mem [MAX_VERTICES];
  logic [31:0] uv_mem  [MAX_VERTICES];
  logic [47:0] nrm_mem [MAX_VERTICES];
  logic [95:0] sum_mem [MAX_VERTICES];
  logic [47:0] pos_q, nrm_q;
  logic [31:0] uv_q;
  logic [95:0] sum_q;

  state_t              state_r;
  mtg_job_t            cur_r;
  logic [1:0]          k_r;
  logic [47:0]         p0_r;
  logic [31:0]         uv0_r;
  logic signed [16:0]  e1_r [3];
  logic signed [16:0]  e2_r [3];
  logic signed [16:0]  du0_r, dv0_r, du1_r, dv1_r;
  logic signed [34:0]  det_r;
  logic                q_neg_r, sat_r;
  logic signed [31:0]  q_r [3];
  logic signed [31:0]  t_r [3];
  logic signed [15:0]  n_r [3];
  logic signed [35:0]  dot_r;
  logic [50:0]         m_r [3];
  logic [2:0]          sgn_r;
  logic [63:0]         sqx_r, res_r, bit_r;
  logic [4:0]          it_r;
  logic [31:0]         len_r;
  logic signed [15:0]  o_r [3];
  logic signed [67:0]  prod_r;
  logic signed [63:0]  acc_r;
  logic                out_valid_r;
  mtg_out_t            out_r;

  logic signed [31:0]  mul_a;
  logic signed [35:0]  mul_b;
  logic [IDX_W-1:0]    rd_slot, sum_wslot;
  logic                sum_we;
  logic [95:0]         sum_wd;
  logic                load_we;
  logic signed [63:0]  diff_c, tot_c, dot_adj, p_c, mag_c;
  logic [63:0]         num_mag;
  logic signed [34:0]  det_neg;
  logic [33:0]         det_mag;
  logic                div_start, div_busy, div_done;
  logic [DVD_W-1:0]    div_dvd, div_q;
  logic [DVS_W-1:0]    div_dvs;
  logic signed [31:0]  clamp_q;
  logic                clamp_sat;
  logic [95:0]         sadd_d;
  logic                sadd_sat;
  logic [63:0]         sq_trial, sqx_nxt, res_nxt;
  logic signed [15:0]  qs_c;
  logic                shift_more;

  function automatic logic [IDX_W-1:0] corner(input mtg_job_t j, input logic [1:0] k);
    case (k)
      2'd1:    corner = j.slot_b;
      2'd2:    corner = j.slot_c;
      default: corner = j.slot_a;
    endcase
  endfunction

  assign pop     = (state_r == S_IDLE) && head.valid;
  assign load_we = pop && (head.job.item.command == CMD_LOAD);

  // memories
  always_ff @(posedge clk) begin
    if (load_we)
      pos_mem[AW'(head.job.slot_a)] <= {head.job.item.pos_z, head.job.item.pos_y,
                                        head.job.item.pos_x};
    pos_q <= pos_mem[AW'(rd_slot)];
  end

  always_ff @(posedge clk) begin
    if (load_we)
      uv_mem[AW'(head.job.slot_a)] <= {head.job.item.tex_v, head.job.item.tex_u};
    uv_q <= uv_mem[AW'(rd_slot)];
  end

  always_ff @(posedge clk) begin
    if (load_we)
      nrm_mem[AW'(head.job.slot_a)] <= {head.job.item.normal_z, head.job.item.normal_y,
                                        head.job.item.normal_x};
    nrm_q <= nrm_mem[AW'(rd_slot)];
  end

  always_ff @(posedge clk) begin
    if (sum_we) sum_mem[AW'(sum_wslot)] <= sum_wd;
    sum_q <= sum_mem[AW'(rd_slot)];
  end

  always_comb begin
    case (state_r)
      S_TRD, S_TSRD: rd_slot = corner(cur_r, k_r);
      default:       rd_slot = cur_r.slot_a;
    endcase
  end

  // shared multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_TM0: begin mul_a = 32'(du0_r); mul_b = 36'(dv1_r); end
      S_TM1: begin mul_a = 32'(dv0_r); mul_b = 36'(du1_r); end
      S_TN0: begin mul_a = 32'(dv1_r); mul_b = 36'(e1_r[k_r]); end
      S_TN1: begin mul_a = 32'(dv0_r); mul_b = 36'(e2_r[k_r]); end
      S_FD0: begin mul_a = t_r[0]; mul_b = 36'(n_r[0]); end
      S_FD1: begin mul_a = t_r[1]; mul_b = 36'(n_r[1]); end
      S_FD2: begin mul_a = t_r[2]; mul_b = 36'(n_r[2]); end
      S_FP0: begin mul_a = 32'(n_r[k_r]); mul_b = dot_r; end
      S_FQ0: begin
        mul_a = $signed({2'b00, m_r[0][29:0]});
        mul_b = $signed({6'b0, m_r[0][29:0]});
      end
      S_FQ1: begin
        mul_a = $signed({2'b00, m_r[1][29:0]});
        mul_b = $signed({6'b0, m_r[1][29:0]});
      end
      S_FQ2: begin
        mul_a = $signed({2'b00, m_r[2][29:0]});
        mul_b = $signed({6'b0, m_r[2][29:0]});
      end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  always_comb begin
    diff_c  = acc_r - 64'(prod_r);
    tot_c   = acc_r + 64'(prod_r);
    num_mag = diff_c[63] ? 64'(-diff_c) : 64'(diff_c);
    det_neg = -det_r;
    det_mag = det_r[34] ? det_neg[33:0] : det_r[33:0];
    dot_adj = tot_c + (tot_c[63] ? 64'sd16383 : 64'sd0);
    p_c     = (64'(t_r[k_r]) <<< 14) - 64'(prod_r);
    mag_c   = p_c[63] ? -p_c : p_c;
    shift_more = (|m_r[0][50:30]) || (|m_r[1][50:30]) || (|m_r[2][50:30]);
    qs_c    = $signed(div_q[15:0]);
  end

  // divider hookup
  assign div_start = (state_r == S_TN2) || (state_r == S_FDV);
  always_comb begin
    if (state_r == S_FDV) begin
      div_dvd = {8'b0, m_r[k_r][29:0], 14'b0};
      div_dvs = {2'b00, len_r};
    end else begin
      div_dvd = {num_mag[33:0], 18'b0};
      div_dvs = det_mag;
    end
  end

  // quotient to 32 bit with clamp
  always_comb begin
    if (q_neg_r) begin
      clamp_sat = (|div_q[51:32]) || (div_q[31] && (|div_q[30:0]));
      clamp_q   = clamp_sat ? 32'sh80000000 : $signed(32'(52'd0 - div_q));
    end else begin
      clamp_sat = |div_q[51:31];
      clamp_q   = clamp_sat ? 32'sh7fffffff : $signed(div_q[31:0]);
    end
  end

  // saturating add of tangent into one corner
  always_comb begin
    logic signed [32:0] s;
    sadd_sat = 1'b0;
    sadd_d   = '0;
    for (int i = 0; i < 3; i++) begin
      s = 33'($signed(sum_q[32*i +: 32])) + 33'(q_r[i]);
      if (s[32] != s[31]) begin
        sadd_sat = 1'b1;
        sadd_d[32*i +: 32] = s[32] ? 32'h80000000 : 32'h7fffffff;
      end else begin
        sadd_d[32*i +: 32] = s[31:0];
      end
    end
  end

  // integer square root step
  always_comb begin
    sq_trial = res_r + bit_r;
    if (sqx_r >= sq_trial) begin
      sqx_nxt = sqx_r - sq_trial;
      res_nxt = (res_r >> 1) + bit_r;
    end else begin
      sqx_nxt = sqx_r;
      res_nxt = res_r >> 1;
    end
  end

  always_comb begin
    sum_we    = 1'b0;
    sum_wslot = cur_r.slot_a;
    sum_wd    = '0;
    if (load_we) begin
      sum_we    = 1'b1;
      sum_wslot = head.job.slot_a;
    end else if (state_r == S_TSADD) begin
      sum_we    = 1'b1;
      sum_wslot = corner(cur_r, k_r);
      sum_wd    = sadd_d;
    end else if (state_r == S_FWB) begin
      sum_we = 1'b1;
      sum_wd = {32'(o_r[2]), 32'(o_r[1]), 32'(o_r[0])};
    end else if (state_r == S_FLEN && len_r == '0) begin
      sum_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (head.valid) begin
            cur_r <= head.job;
            k_r   <= '0;
            sat_r <= 1'b0;
            case (head.job.item.command)
              CMD_TRI: state_r <= S_TRD;
              CMD_FIN: state_r <= S_FRD;
              default: begin
                out_valid_r        <= 1'b1;
                out_r.vertex_index <= head.job.item.index_a;
                out_r.tangent_x    <= '0;
                out_r.tangent_y    <= '0;
                out_r.tangent_z    <= '0;
                out_r.status       <= ST_OK;
              end
            endcase
          end
        end
        S_TRD: state_r <= S_TCAP;
        S_TCAP: begin
          case (k_r)
            2'd0: begin
              p0_r  <= pos_q;
              uv0_r <= uv_q;
            end
            2'd1: begin
              for (int i = 0; i < 3; i++)
                e1_r[i] <= 17'($signed(pos_q[16*i +: 16])) - 17'($signed(p0_r[16*i +: 16]));
              du0_r <= 17'($signed(uv_q[15:0])) - 17'($signed(uv0_r[15:0]));
              dv0_r <= 17'($signed(uv_q[31:16])) - 17'($signed(uv0_r[31:16]));
            end
            default: begin
              for (int i = 0; i < 3; i++)
                e2_r[i] <= 17'($signed(pos_q[16*i +: 16])) - 17'($signed(p0_r[16*i +: 16]));
              du1_r <= 17'($signed(uv_q[15:0])) - 17'($signed(uv0_r[15:0]));
              dv1_r <= 17'($signed(uv_q[31:16])) - 17'($signed(uv0_r[31:16]));
            end
          endcase
          if (k_r == 2'd2) begin
            k_r     <= '0;
            state_r <= S_TM0;
          end else begin
            k_r     <= k_r + 1'b1;
            state_r <= S_TRD;
          end
        end
        S_TM0: state_r <= S_TM1;
        S_TM1: begin
          acc_r   <= 64'(prod_r);
          state_r <= S_TM2;
        end
        S_TM2: begin
          det_r   <= 35'(diff_c);
          state_r <= S_TCHK;
        end
        S_TCHK: begin
          if (det_mag <= {18'b0, limit}) begin
            out_valid_r        <= 1'b1;
            out_r.vertex_index <= cur_r.item.index_a;
            out_r.tangent_x    <= '0;
            out_r.tangent_y    <= '0;
            out_r.tangent_z    <= '0;
            out_r.status       <= ST_DEGEN;
            state_r            <= S_IDLE;
          end else begin
            state_r <= S_TN0;
          end
        end
        S_TN0: state_r <= S_TN1;
        S_TN1: begin
          acc_r   <= 64'(prod_r);
          state_r <= S_TN2;
        end
        S_TN2: begin
          q_neg_r <= diff_c[63] ^ det_r[34];
          state_r <= S_TDIV;
        end
        S_TDIV: begin
          if (div_done) begin
            q_r[k_r] <= clamp_q;
            if (clamp_sat) sat_r <= 1'b1;
            if (k_r == 2'd2) begin
              k_r     <= '0;
              state_r <= S_TSRD;
            end else begin
              k_r     <= k_r + 1'b1;
              state_r <= S_TN0;
            end
          end
        end
        S_TSRD: state_r <= S_TSADD;
        S_TSADD: begin
          if (k_r == 2'd2) begin
            out_valid_r        <= 1'b1;
            out_r.vertex_index <= cur_r.item.index_a;
            out_r.tangent_x    <= '0;
            out_r.tangent_y    <= '0;
            out_r.tangent_z    <= '0;
            out_r.status       <= (sat_r || sadd_sat) ? ST_SAT : ST_OK;
            state_r            <= S_IDLE;
          end else begin
            if (sadd_sat) sat_r <= 1'b1;
            k_r     <= k_r + 1'b1;
            state_r <= S_TSRD;
          end
        end
        S_FRD: state_r <= S_FCAP;
        S_FCAP: begin
          for (int i = 0; i < 3; i++) begin
            t_r[i] <= $signed(sum_q[32*i +: 32]);
            n_r[i] <= $signed(nrm_q[16*i +: 16]);
          end
          state_r <= S_FD0;
        end
        S_FD0: state_r <= S_FD1;
        S_FD1: begin
          acc_r   <= 64'(prod_r);
          state_r <= S_FD2;
        end
        S_FD2: begin
          acc_r   <= tot_c;
          state_r <= S_FD3;
        end
        S_FD3: begin
          dot_r   <= 36'(dot_adj >>> 14);
          k_r     <= '0;
          state_r <= S_FP0;
        end
        S_FP0: state_r <= S_FP1;
        S_FP1: begin
          m_r[k_r]   <= 51'(mag_c);
          sgn_r[k_r] <= p_c[63];
          if (k_r == 2'd2) begin
            k_r     <= '0;
            state_r <= S_FSH;
          end else begin
            k_r     <= k_r + 1'b1;
            state_r <= S_FP0;
          end
        end
        S_FSH: begin
          if (shift_more) begin
            for (int i = 0; i < 3; i++) m_r[i] <= m_r[i] >> 1;
          end else begin
            state_r <= S_FQ0;
          end
        end
        S_FQ0: state_r <= S_FQ1;
        S_FQ1: begin
          acc_r   <= 64'(prod_r);
          state_r <= S_FQ2;
        end
        S_FQ2: begin
          acc_r   <= tot_c;
          state_r <= S_FQ3;
        end
        S_FQ3: begin
          sqx_r   <= 64'(tot_c);
          res_r   <= '0;
          bit_r   <= 64'd1 << 62;
          it_r    <= '0;
          state_r <= S_FSQ;
        end
        S_FSQ: begin
          sqx_r <= sqx_nxt;
          res_r <= res_nxt;
          bit_r <= bit_r >> 2;
          it_r  <= it_r + 1'b1;
          if (it_r == 5'd31) begin
            len_r   <= res_nxt[31:0];
            state_r <= S_FLEN;
          end
        end
        S_FLEN: begin
          k_r <= '0;
          if (len_r == '0) begin
            out_valid_r        <= 1'b1;
            out_r.vertex_index <= cur_r.item.index_a;
            out_r.tangent_x    <= '0;
            out_r.tangent_y    <= '0;
            out_r.tangent_z    <= '0;
            out_r.status       <= ST_ZERO;
            state_r            <= S_IDLE;
          end else begin
            state_r <= S_FDV;
          end
        end
        S_FDV: state_r <= S_FDW;
        S_FDW: begin
          if (div_done) begin
            o_r[k_r] <= sgn_r[k_r] ? -qs_c : qs_c;
            if (k_r == 2'd2) begin
              state_r <= S_FWB;
            end else begin
              k_r     <= k_r + 1'b1;
              state_r <= S_FDV;
            end
          end
        end
        S_FWB: begin
          out_valid_r        <= 1'b1;
          out_r.vertex_index <= cur_r.item.index_a;
          out_r.tangent_x    <= o_r[0];
          out_r.tangent_y    <= o_r[1];
          out_r.tangent_z    <= o_r[2];
          out_r.status       <= ST_OK;
          state_r            <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  mtg_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_q)
  );

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

`ifndef SYNTH
  a_zero_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_r.status == ST_ZERO) |->
      (out_r.tangent_x == '0) && (out_r.tangent_y == '0) && (out_r.tangent_z == '0))
    else $error("zero-tangent result carries a tangent");
  a_degen_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_r.status == ST_DEGEN) |->
      (out_r.tangent_x == '0) && (out_r.tangent_y == '0) && (out_r.tangent_z == '0))
    else $error("skipped triangle carries a tangent");
  a_div_free: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_busy)
    else $error("divider restarted while busy");
  a_idle_div: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !div_busy)
    else $error("divider busy with sequencer idle");
`endif

endmodule
`default_nettype wire
